// File: hw/rtl/wavhp_pkg.sv
// Shared types and constants for the WAV header parser and peak tracker.
// Used by wavhp_ctrl, wavhp_dp, wavhp_div and wav_header_parse_minmax.
`default_nettype none

package wavhp_pkg;

  // Parse status codes
  localparam logic [2:0] StHeader   = 3'd0;
  localparam logic [2:0] StSamples  = 3'd1;
  localparam logic [2:0] StDone     = 3'd2;
  localparam logic [2:0] StBadRiff  = 3'd3;
  localparam logic [2:0] StBadWave  = 3'd4;
  localparam logic [2:0] StBadFmt   = 3'd5;
  localparam logic [2:0] StBadData  = 3'd6;
  localparam logic [2:0] StZeroBits = 3'd7;

  // Chunk markers as seen in the little-endian shift word
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  // Header byte offsets where a field or marker completes
  localparam logic [5:0] PosRiff   = 6'd3;
  localparam logic [5:0] PosWave   = 6'd11;
  localparam logic [5:0] PosFmt    = 6'd15;
  localparam logic [5:0] PosFormat = 6'd21;
  localparam logic [5:0] PosChan   = 6'd23;
  localparam logic [5:0] PosRate   = 6'd27;
  localparam logic [5:0] PosWidth  = 6'd35;
  localparam logic [5:0] PosData   = 6'd39;
  localparam logic [5:0] PosSize   = 6'd43;
  localparam logic [5:0] HdrLen    = 6'd44;

  localparam int unsigned CountW   = 35;
  localparam int unsigned DivSteps = CountW;
  localparam int unsigned TdataOutW = 200;

  localparam logic signed [15:0] PeakHighInit = -16'sd32768;
  localparam logic signed [15:0] PeakLowInit  = 16'sd32767;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input request taken this cycle
    logic div_fin;   // divider result ready, commit sample count
    logic load_out;  // copy current result into output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // current input byte closes the header and the sample width is nonzero
  } dp_sts_t;

endpackage : wavhp_pkg

`default_nettype wire

// File: hw/rtl/wavhp_div.sv
// Serial restoring divider, one quotient bit per cycle, for the sample count.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_div
  import wavhp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CountW-1:0] dividend_i,
  input  wire logic [15:0]       divisor_i,
  output logic                   done_o,
  output logic [CountW-1:0]      quotient_o
);

  logic [CountW-1:0] dvd_q, dvd_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       dvs_q;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [16:0]       trial;
  logic [16:0]       diff;
  logic              fits;

  assign trial = {rem_q, dvd_q[CountW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'(DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[15:0] : trial[15:0];
      dvd_d = {dvd_q[CountW-2:0], fits};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0)
    else $error("divider busy with empty step count");
`endif

endmodule : wavhp_div

`default_nettype wire

// File: hw/rtl/wavhp_ctrl.sv
// Controller: input/output handshake, pending-result tracking and divide wait.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_ctrl
  import wavhp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  input  wire logic    div_done_i,
  output logic         div_start_o,
  output ctrl_cmd_t    cmd_o
);

  localparam logic SIdle = 1'b0;
  localparam logic SDiv  = 1'b1;

  logic state_q, state_d;
  logic pend_q, pend_d;
  logic oval_q, oval_d;
  logic load_out;
  logic accept;
  logic div_fin;

  assign load_out   = pend_q && (!oval_q || out_ready_i);
  assign in_ready_o = (state_q == SIdle) && (!pend_q || load_out);
  assign accept     = in_valid_i && in_ready_o;
  assign div_fin    = (state_q == SDiv) && div_done_i;
  assign div_start_o = accept && sts_i.need_div;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (div_start_o) state_d = SDiv;
      SDiv:  if (div_done_i)  state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (div_fin) begin
      pend_d = 1'b1;
    end else if (accept) begin
      pend_d = !sts_i.need_div;
    end else if (load_out) begin
      pend_d = 1'b0;
    end
    oval_d = oval_q;
    if (load_out) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pend_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o    = oval_q;
  assign cmd_o.accept   = accept;
  assign cmd_o.div_fin  = div_fin;
  assign cmd_o.load_out = load_out;

`ifndef ASSERT_OFF
  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDiv |-> !accept && !pend_q)
    else $error("request taken or result pending during divide");
  a_start_enters_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_o |=> state_q == SDiv)
    else $error("divide start did not enter wait state");
  a_fin_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_fin |=> pend_q)
    else $error("divide finish did not post a result");
  a_load_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> oval_q)
    else $error("output load lost");
`endif

endmodule : wavhp_ctrl

`default_nettype wire

// File: hw/rtl/wavhp_dp.sv
// Datapath: header shift word, field capture, sample assembly, peak tracking
// and the output register. Depends on wavhp_pkg; commands from wavhp_ctrl.
`default_nettype none

module wavhp_dp
  import wavhp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic [7:0]        file_byte_i,
  input  wire logic              first_of_file_i,
  output logic [CountW-1:0]      dividend_o,
  output logic [15:0]            divisor_o,
  input  wire logic [CountW-1:0] quotient_i,
  output logic [2:0]             status_o,
  output logic [15:0]            audio_format_o,
  output logic [15:0]            channel_count_o,
  output logic [31:0]            rate_hz_o,
  output logic [15:0]            sample_width_o,
  output logic [31:0]            payload_bytes_o,
  output logic [CountW-1:0]      sample_total_o,
  output logic                   sample_valid_o,
  output logic signed [15:0]     sample_value_o,
  output logic signed [15:0]     peak_high_o,
  output logic signed [15:0]     peak_low_o
);

  // parse state
  logic [5:0]               pos_q, pos_d;
  logic [31:0]              shift_q, shift_d;
  logic [2:0]               stat_q, stat_d;
  logic [15:0]              fmt_q, fmt_d;
  logic [15:0]              chan_q, chan_d;
  logic [31:0]              rate_q, rate_d;
  logic [15:0]              width_q, width_d;
  logic [31:0]              size_q, size_d;
  logic [CountW-1:0]        target_q, target_d;
  logic [CountW-1:0]        ndone_q, ndone_d;
  logic [8:0]               lowb_q, lowb_d;
  logic signed [15:0]       max_q, max_d;
  logic signed [15:0]       min_q, min_d;
  logic                     sval_q, sval_d;
  logic signed [15:0]       sdat_q, sdat_d;

  // state seen by this byte, after an optional file restart
  logic [5:0]               b_pos;
  logic [31:0]              b_shift;
  logic [2:0]               b_stat;
  logic [15:0]              b_fmt, b_chan, b_width;
  logic [31:0]              b_rate, b_size;
  logic [CountW-1:0]        b_target, b_ndone;
  logic [8:0]               b_lowb;
  logic signed [15:0]       b_max, b_min;
  logic [31:0]              shift_new;
  logic                     in_hdr;
  logic signed [15:0]       smp;
  logic [CountW-1:0]        ndone_inc;

  always_comb begin
    if (first_of_file_i) begin
      b_pos    = '0;
      b_shift  = '0;
      b_stat   = StHeader;
      b_fmt    = '0;
      b_chan   = '0;
      b_rate   = '0;
      b_width  = '0;
      b_size   = '0;
      b_target = '0;
      b_ndone  = '0;
      b_lowb   = '0;
      b_max    = PeakHighInit;
      b_min    = PeakLowInit;
    end else begin
      b_pos    = pos_q;
      b_shift  = shift_q;
      b_stat   = stat_q;
      b_fmt    = fmt_q;
      b_chan   = chan_q;
      b_rate   = rate_q;
      b_width  = width_q;
      b_size   = size_q;
      b_target = target_q;
      b_ndone  = ndone_q;
      b_lowb   = lowb_q;
      b_max    = max_q;
      b_min    = min_q;
    end
  end

  assign shift_new = {file_byte_i, b_shift[31:8]};
  assign in_hdr    = (b_stat == StHeader) && (b_pos < HdrLen);
  assign smp       = {file_byte_i, b_lowb[7:0]};
  assign ndone_inc = b_ndone + 1'b1;

  assign sts_o.need_div = in_hdr && (b_pos == PosSize) && (b_width != 16'd0);
  assign dividend_o     = {shift_new, 3'b000};
  assign divisor_o      = b_width;

  always_comb begin
    pos_d    = pos_q;
    shift_d  = shift_q;
    stat_d   = stat_q;
    fmt_d    = fmt_q;
    chan_d   = chan_q;
    rate_d   = rate_q;
    width_d  = width_q;
    size_d   = size_q;
    target_d = target_q;
    ndone_d  = ndone_q;
    lowb_d   = lowb_q;
    max_d    = max_q;
    min_d    = min_q;
    sval_d   = sval_q;
    sdat_d   = sdat_q;
    if (cmd_i.div_fin) begin
      target_d = quotient_i;
      stat_d   = (quotient_i == '0) ? StDone : StSamples;
    end else if (cmd_i.accept) begin
      pos_d    = b_pos;
      shift_d  = b_shift;
      stat_d   = b_stat;
      fmt_d    = b_fmt;
      chan_d   = b_chan;
      rate_d   = b_rate;
      width_d  = b_width;
      size_d   = b_size;
      target_d = b_target;
      ndone_d  = b_ndone;
      lowb_d   = b_lowb;
      max_d    = b_max;
      min_d    = b_min;
      sval_d   = 1'b0;
      sdat_d   = '0;
      if (in_hdr) begin
        shift_d = shift_new;
        pos_d   = b_pos + 6'd1;
        case (b_pos)
          PosRiff:   if (shift_new != TagRiff) stat_d = StBadRiff;
          PosWave:   if (shift_new != TagWave) stat_d = StBadWave;
          PosFmt:    if (shift_new != TagFmt)  stat_d = StBadFmt;
          PosFormat: fmt_d   = shift_new[31:16];
          PosChan:   chan_d  = shift_new[31:16];
          PosRate:   rate_d  = shift_new;
          PosWidth:  width_d = shift_new[31:16];
          PosData:   if (shift_new != TagData) stat_d = StBadData;
          PosSize: begin
            size_d = shift_new;
            // nonzero width: status and count follow from the divider
            if (b_width == 16'd0) stat_d = StZeroBits;
          end
          default: ;
        endcase
      end else if (b_stat == StSamples) begin
        if (b_lowb[8]) begin
          lowb_d  = '0;
          sval_d  = 1'b1;
          sdat_d  = smp;
          if (smp > b_max) max_d = smp;
          if (smp < b_min) min_d = smp;
          ndone_d = ndone_inc;
          if (ndone_inc >= b_target) stat_d = StDone;
        end else begin
          lowb_d = {1'b1, file_byte_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      shift_q  <= '0;
      stat_q   <= StHeader;
      fmt_q    <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      width_q  <= '0;
      size_q   <= '0;
      target_q <= '0;
      ndone_q  <= '0;
      lowb_q   <= '0;
      max_q    <= PeakHighInit;
      min_q    <= PeakLowInit;
      sval_q   <= 1'b0;
      sdat_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      stat_q   <= stat_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      width_q  <= width_d;
      size_q   <= size_d;
      target_q <= target_d;
      ndone_q  <= ndone_d;
      lowb_q   <= lowb_d;
      max_q    <= max_d;
      min_q    <= min_d;
      sval_q   <= sval_d;
      sdat_q   <= sdat_d;
    end
  end

  // output register, loaded from the posted result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o        <= stat_q;
      audio_format_o  <= fmt_q;
      channel_count_o <= chan_q;
      rate_hz_o       <= rate_q;
      sample_width_o  <= width_q;
      payload_bytes_o <= size_q;
      sample_total_o  <= target_q;
      sample_valid_o  <= sval_q;
      sample_value_o  <= sdat_q;
      peak_high_o     <= max_q;
      peak_low_o      <= min_q;
    end
  end

`ifndef ASSERT_OFF
  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sval_q |-> (max_q >= min_q) && (sdat_q <= max_q) && (sdat_q >= min_q))
    else $error("sample outside tracked peaks");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q == StSamples |-> ndone_q < target_q)
    else $error("sample count passed target while sampling");
  a_header_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q == StHeader |-> pos_q <= HdrLen)
    else $error("header position out of range");
`endif

endmodule : wavhp_dp

`default_nettype wire

// File: hw/rtl/wav_header_parse_minmax.sv
// WAV header parser with signed 16-bit peak tracking; top level.
// Depends on wavhp_pkg, wavhp_ctrl, wavhp_dp and wavhp_div.
//
// Usage: file bytes enter on the s_axis channel, one byte per request, with
// tuser high on the first byte of each file to restart the parse. Every byte
// yields exactly one result request on m_axis carrying the parse status, the
// captured header fields, the sample count and the running peaks.
// Each taken byte's result is posted, then loaded into the output register. The last
// header byte (offset 43), if the header is good and the sample width nonzero, starts
// a serial divide for the sample count, one quotient bit per cycle; no byte is taken
// until it ends. Other bytes are taken one per cycle while the receiver keeps up.
// A result waits in the output register while the next byte is taken; with
// the receiver stalled, the block then holds off the sender (tready low) until
// the output register drains.
// Reset (rst_ni low, asynchronous) clears the parse to the header state, with
// peaks at -32768 / 32767 and no result pending.
`default_nettype none

module wav_header_parse_minmax
  import wavhp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] file_byte
  input  wire logic                 s_axis_tuser_i,   // [0] first_of_file
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [15:0] audio_format, [31:16] channel_count, [63:32] rate_hz,
  // [79:64] sample_width, [111:80] payload_bytes, [146:112] sample_total,
  // [162:147] sample_value, [178:163] peak_high, [194:179] peak_low, rest 0
  output logic [TdataOutW-1:0]      m_axis_tdata_o,
  output logic [3:0]                m_axis_tuser_o    // [2:0] status, [3] sample_valid
);

  ctrl_cmd_t          cmd;
  dp_sts_t            sts;
  logic               div_start;
  logic               div_done;
  logic [CountW-1:0]  dividend;
  logic [15:0]        divisor;
  logic [CountW-1:0]  quotient;
  logic [2:0]         status;
  logic [15:0]        audio_format;
  logic [15:0]        channel_count;
  logic [31:0]        rate_hz;
  logic [15:0]        sample_width;
  logic [31:0]        payload_bytes;
  logic [CountW-1:0]  sample_total;
  logic               sample_valid;
  logic signed [15:0] sample_value;
  logic signed [15:0] peak_high;
  logic signed [15:0] peak_low;

  wavhp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .div_done_i  (div_done),
    .div_start_o (div_start),
    .cmd_o       (cmd)
  );

  wavhp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .file_byte_i     (s_axis_tdata_i),
    .first_of_file_i (s_axis_tuser_i),
    .dividend_o      (dividend),
    .divisor_o       (divisor),
    .quotient_i      (quotient),
    .status_o        (status),
    .audio_format_o  (audio_format),
    .channel_count_o (channel_count),
    .rate_hz_o       (rate_hz),
    .sample_width_o  (sample_width),
    .payload_bytes_o (payload_bytes),
    .sample_total_o  (sample_total),
    .sample_valid_o  (sample_valid),
    .sample_value_o  (sample_value),
    .peak_high_o     (peak_high),
    .peak_low_o      (peak_low)
  );

  wavhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign m_axis_tdata_o = {5'b0, peak_low, peak_high, sample_value, sample_total,
                           payload_bytes, sample_width, rate_hz, channel_count,
                           audio_format};
  assign m_axis_tuser_o = {sample_valid, status};

endmodule : wav_header_parse_minmax

`default_nettype wire
